/* rtl/core/tawc_pkg.sv */
// ----------------------------------------------------------------------------
// tawc_pkg
// Shared types and constants for the triangle alpha-weighted color block.
// ----------------------------------------------------------------------------
package tawc_pkg;

  localparam int MAX_WIDTH   = 128;
  localparam int MAX_HEIGHT  = 128;
  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW          = $clog2(STORE_DEPTH);
  localparam int XW          = $clog2(MAX_WIDTH + 1);
  localparam int YW          = $clog2(MAX_HEIGHT + 1);
  localparam int CW          = AW + 1;
  localparam int SW          = 8 + 8 + CW;
  localparam int AAW         = 8 + CW;

  localparam logic [1:0] SRC_MEAN   = 2'd0;
  localparam logic [1:0] SRC_OPAQUE = 2'd1;
  localparam logic [1:0] SRC_CLEAR  = 2'd2;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_TRI  = 1'b1;

  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  typedef struct packed {
    logic       req_type;
    logic [13:0] pixel_addr;
    logic [7:0] load_red;
    logic [7:0] load_green;
    logic [7:0] load_blue;
    logic [7:0] load_alpha;
    logic [7:0] vertex_x0;
    logic [7:0] vertex_y0;
    logic [7:0] vertex_x1;
    logic [7:0] vertex_y1;
    logic [7:0] vertex_x2;
    logic [7:0] vertex_y2;
  } req_t;

  typedef struct packed {
    logic [7:0]  color_red;
    logic [7:0]  color_green;
    logic [7:0]  color_blue;
    logic [7:0]  color_alpha;
    logic [1:0]  color_source;
    logic [14:0] inside_count;
  } result_t;

  // divider handshake
  typedef struct packed {
    logic          go;
    logic [SW-1:0] num;
    logic [SW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic          done;
    logic [SW-1:0] quo;
  } div_rsp_t;

endpackage

/* rtl/core/tawc_div.sv */
// ----------------------------------------------------------------------------
// tawc_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tawc_div (
  input  logic               clk,
  input  logic               rst,
  input  tawc_pkg::div_req_t req,
  output tawc_pkg::div_rsp_t rsp
);
  import tawc_pkg::*;

  localparam int NW = $clog2(SW + 1);

  logic          busy;
  logic          fin;
  logic [NW-1:0] cnt;
  logic [SW-1:0] quo;
  logic [SW-1:0] rem;
  logic [SW-1:0] den;
  logic [SW:0]   trial;

  assign trial = {rem, quo[SW-1]} - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
    end else begin
      fin <= 1'b0;
      if (req.go) begin
        busy <= 1'b1;
        cnt  <= NW'(SW);
        quo  <= req.num;
        rem  <= '0;
        den  <= req.den;
      end else if (busy) begin
        if (trial[SW]) begin
          rem <= {rem[SW-2:0], quo[SW-1]};
          quo <= {quo[SW-2:0], 1'b0};
        end else begin
          rem <= trial[SW-1:0];
          quo <= {quo[SW-2:0], 1'b1};
        end
        cnt <= cnt - 1'b1;
        if (cnt == NW'(1)) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = fin;
  assign rsp.quo  = quo;

endmodule

/* rtl/core/triangle_alpha_weighted_color.sv */
// ----------------------------------------------------------------------------
// triangle_alpha_weighted_color
// Pixel store plus raster scan of a triangle's box, alpha-weighted mean color.
// ----------------------------------------------------------------------------
// Load word: written to the store at start, then busy in ST_OUT; no strobe.
// Triangle word: a first pass sums the opaque inside pixels of the box, then four divisions
// give the mean; if there are none, a second pass seeks the first opaque box pixel and
// answers clear if it finds none. One word at a time.
// Reset (rst, synchronous) idles the sequencer and sets width/height to 128;
// the pixel store keeps no reset. The result strobe cannot be stalled.
module triangle_alpha_weighted_color (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  tawc_pkg::req_t    req,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [7:0]        cfg_data,
  output logic              done,
  output tawc_pkg::result_t result
);
  import tawc_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SETUP = 3'd1;
  localparam logic [2:0] ST_READ  = 3'd2;
  localparam logic [2:0] ST_ACC   = 3'd3;
  localparam logic [2:0] ST_DIV   = 3'd4;
  localparam logic [2:0] ST_WAIT  = 3'd5;
  localparam logic [2:0] ST_OUT   = 3'd6;

  logic [2:0] state;
  logic [7:0] image_width;
  logic [7:0] image_height;

  // pixel store
  logic [31:0] store [STORE_DEPTH];
  logic [31:0] rd_data;
  logic [AW-1:0] rd_addr;

  // triangle registers
  logic signed [9:0] vx0, vy0, vx1, vy1, vx2, vy2;
  logic [XW-1:0] w_c, left, right, x;
  logic [YW-1:0] top, bottom, y;
  logic [AW-1:0] row_base;
  logic          pass2;
  logic          cur_in;
  logic [SW-1:0] sr, sg, sb;
  logic [AAW-1:0] sa;
  logic [CW-1:0] count;
  logic [1:0]    div_sel;
  logic [7:0]    qr, qg, qb;
  div_req_t      dreq;
  div_rsp_t      drsp;

  tawc_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  // clamp helpers
  function automatic logic [XW-1:0] clampw(input logic [7:0] v);
    if (v == 8'd0) return XW'(1);
    if (v > 8'(MAX_WIDTH)) return XW'(MAX_WIDTH);
    return XW'(v);
  endfunction
  function automatic logic [YW-1:0] clamph(input logic [7:0] v);
    if (v == 8'd0) return YW'(1);
    if (v > 8'(MAX_HEIGHT)) return YW'(MAX_HEIGHT);
    return YW'(v);
  endfunction

  logic [7:0] mnx, mxx, mny, mxy;
  always_comb begin
    mnx = req.vertex_x0; mxx = req.vertex_x0;
    mny = req.vertex_y0; mxy = req.vertex_y0;
    if (req.vertex_x1 < mnx) mnx = req.vertex_x1;
    if (req.vertex_x2 < mnx) mnx = req.vertex_x2;
    if (req.vertex_x1 > mxx) mxx = req.vertex_x1;
    if (req.vertex_x2 > mxx) mxx = req.vertex_x2;
    if (req.vertex_y1 < mny) mny = req.vertex_y1;
    if (req.vertex_y2 < mny) mny = req.vertex_y2;
    if (req.vertex_y1 > mxy) mxy = req.vertex_y1;
    if (req.vertex_y2 > mxy) mxy = req.vertex_y2;
  end

  logic [XW-1:0] left_n, right_n;
  logic [YW-1:0] top_n, bottom_n;
  logic [XW-1:0] wn;
  logic [YW-1:0] hn;
  always_comb begin
    wn = clampw(image_width);
    hn = clamph(image_height);
    left_n   = ({1'b0, mnx} > 9'(wn - 1'b1)) ? wn - 1'b1 : XW'(mnx);
    right_n  = (mxx == 8'd0) ? '0 :
               ({1'b0, mxx} - 9'd1 > 9'(wn - 1'b1)) ? wn - 1'b1 : XW'(mxx - 8'd1);
    top_n    = ({1'b0, mny} > 9'(hn - 1'b1)) ? hn - 1'b1 : YW'(mny);
    bottom_n = (mxy == 8'd0) ? '0 :
               ({1'b0, mxy} - 9'd1 > 9'(hn - 1'b1)) ? hn - 1'b1 : YW'(mxy - 8'd1);
  end

  // edge functions at the current pixel centre, twice scaled
  logic signed [10:0] cx2, cy2;
  logic signed [22:0] e0, e1, e2;
  always_comb begin
    cx2 = 11'(signed'({3'b0, x})) * 11'sd2 + 11'sd1;
    cy2 = 11'(signed'({3'b0, y})) * 11'sd2 + 11'sd1;
    e0 = 23'(cx2 - 2 * vx0) * 23'(vy1 - vy0) - 23'(cy2 - 2 * vy0) * 23'(vx1 - vx0);
    e1 = 23'(cx2 - 2 * vx1) * 23'(vy2 - vy1) - 23'(cy2 - 2 * vy1) * 23'(vx2 - vx1);
    e2 = 23'(cx2 - 2 * vx2) * 23'(vy0 - vy2) - 23'(cy2 - 2 * vy2) * 23'(vx0 - vx2);
  end
  logic neg, pos, inside_now;
  assign neg = e0[22] | e1[22] | e2[22];
  assign pos = (!e0[22] && e0 != 0) || (!e1[22] && e1 != 0) || (!e2[22] && e2 != 0);
  assign inside_now = !(neg && pos);

  assign rd_addr = row_base + AW'(x);
  assign busy = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst && start && !busy && req.req_type == REQ_LOAD &&
        {1'b0, req.pixel_addr} < 15'(STORE_DEPTH))
      store[AW'(req.pixel_addr)] <= {req.load_alpha, req.load_blue, req.load_green, req.load_red};
    rd_data <= store[rd_addr];
  end

  logic last_px;
  assign last_px = (x == right) && (y == bottom);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      image_width  <= 8'd128;
      image_height <= 8'd128;
      done         <= 1'b0;
      dreq.go      <= 1'b0;
    end else begin
      done    <= 1'b0;
      dreq.go <= 1'b0;
      if (cfg_we) begin
        if (cfg_index == CFG_WIDTH) image_width <= cfg_data;
        else image_height <= cfg_data;
      end
      case (state)
        ST_IDLE: begin
          if (start && req.req_type == REQ_TRI) begin
            vx0 <= 10'(req.vertex_x0); vy0 <= 10'(req.vertex_y0);
            vx1 <= 10'(req.vertex_x1); vy1 <= 10'(req.vertex_y1);
            vx2 <= 10'(req.vertex_x2); vy2 <= 10'(req.vertex_y2);
            w_c <= wn;
            left <= left_n; right <= right_n; top <= top_n; bottom <= bottom_n;
            state <= ST_SETUP;
          end else if (start) begin
            state <= ST_OUT; // load: back to idle through ST_OUT, no strobe
          end
        end
        ST_SETUP: begin
          if (left > right || top > bottom) begin
            // empty box: nothing to scan, answer transparent black
            result <= {8'd0, 8'd0, 8'd0, 8'd0, SRC_CLEAR, 15'd0};
            done   <= 1'b1;
            state  <= ST_IDLE;
          end else begin
            x <= left; y <= top;
            row_base <= AW'(top) * AW'(w_c);
            sr <= '0; sg <= '0; sb <= '0; sa <= '0; count <= '0;
            pass2 <= 1'b0;
            state <= ST_READ;
          end
        end
        ST_READ: begin
          // store read issued this cycle
          cur_in <= inside_now;
          state  <= ST_ACC;
        end
        ST_ACC: begin
          if (!pass2) begin
            if (cur_in && rd_data[31:24] != 0) begin
              sr <= sr + SW'(rd_data[7:0] * rd_data[31:24]);
              sg <= sg + SW'(rd_data[15:8] * rd_data[31:24]);
              sb <= sb + SW'(rd_data[23:16] * rd_data[31:24]);
              sa <= sa + AAW'(rd_data[31:24]);
              count <= count + 1'b1;
            end
          end else if (rd_data[31:24] != 0) begin
            result <= {rd_data[7:0], rd_data[15:8], rd_data[23:16], rd_data[31:24],
                       SRC_OPAQUE, 15'd0};
            done  <= 1'b1;
            state <= ST_IDLE;
          end
          if (!(pass2 && rd_data[31:24] != 0)) begin
            if (last_px) begin
              x <= left; y <= top;
              row_base <= AW'(top) * AW'(w_c);
              if (pass2) begin
                result <= {8'd0, 8'd0, 8'd0, 8'd0, SRC_CLEAR, 15'd0};
                done  <= 1'b1;
                state <= ST_IDLE;
              end else if (count != 0 || (cur_in && rd_data[31:24] != 0)) begin
                div_sel <= 2'd0;
                state   <= ST_DIV;
              end else begin
                pass2 <= 1'b1;
                state <= ST_READ;
              end
            end else begin
              if (x == right) begin
                x <= left; y <= y + 1'b1;
                row_base <= row_base + AW'(w_c);
              end else begin
                x <= x + 1'b1;
              end
              state <= ST_READ;
            end
          end
        end
        ST_DIV: begin
          dreq.go <= 1'b1;
          case (div_sel)
            2'd0: begin dreq.num <= sr; dreq.den <= SW'(sa); end
            2'd1: begin dreq.num <= sg; dreq.den <= SW'(sa); end
            2'd2: begin dreq.num <= sb; dreq.den <= SW'(sa); end
            default: begin dreq.num <= SW'(sa); dreq.den <= SW'(count); end
          endcase
          state <= ST_WAIT;
        end
        ST_WAIT: begin
          if (drsp.done) begin
            case (div_sel)
              2'd0: qr <= drsp.quo[7:0];
              2'd1: qg <= drsp.quo[7:0];
              2'd2: qb <= drsp.quo[7:0];
              default: begin
                result <= {qr, qg, qb, drsp.quo[7:0], SRC_MEAN, 15'(count)};
                done   <= 1'b1;
              end
            endcase
            div_sel <= div_sel + 1'b1;
            state   <= (div_sel == 2'd3) ? ST_IDLE : ST_DIV;
          end
        end
        ST_OUT: state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
